// ===== hdl/lfbd_pkg.sv =====
package lfbd_pkg;

  localparam int ROUNDS = 36;
  localparam int SLOT_W = 6;
  localparam int KEY_W  = 32;
  localparam int BLK_W  = 64;
  localparam int BYTES  = BLK_W / 8;
  localparam int PAD_W  = BLK_W - SLOT_W - KEY_W;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_e;

  typedef struct packed {
    logic             vld;
    action_e          act;
    logic [BLK_W-1:0] data;
  } req_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h0, 4'hF, 4'hA, 4'h2, 4'hB, 4'h9, 4'h5,
    4'h8, 4'h3, 4'hD, 4'h7, 4'h1, 4'hE, 4'h6, 4'h4
  };

  function automatic logic [BLK_W-1:0] feistel_f(logic [BLK_W-1:0] blk,
                                                 logic [KEY_W-1:0] rk);
    logic [BLK_W-1:0] res;
    res = blk;
    for (int j = 0; j < BYTES; j++) begin
      res[8*j+4 +: 4] = blk[8*j+4 +: 4] ^ SBOX[blk[8*j +: 4] ^ rk[4*j +: 4]];
    end
    return res;
  endfunction

  function automatic logic [BLK_W-1:0] inv_shuffle(logic [BLK_W-1:0] blk);
    logic [7:0]       b [BYTES];
    logic [7:0]       t;
    logic [BLK_W-1:0] res;
    for (int k = 0; k < BYTES; k++) begin
      b[k] = blk[8*k +: 8];
    end
    t    = b[0];
    b[0] = {b[0][7:4], b[2][7:4]};
    b[2] = {b[6][3:0], b[2][3:0]};
    b[6] = {b[6][7:4], b[7][7:4]};
    b[7] = {b[7][3:0], b[7][3:0]};
    b[7] = {b[7][7:4], b[5][7:4]};
    b[5] = {b[1][3:0], b[5][3:0]};
    b[1] = {b[1][7:4], b[0][7:4]};
    b[0] = {t[3:0],    b[0][3:0]};

    t    = b[1];
    b[1] = {b[2][3:0], b[1][3:0]};
    b[2] = {b[2][7:4], b[3][7:4]};
    b[3] = {b[4][3:0], b[3][3:0]};
    b[4] = {b[4][7:4], b[6][7:4]};
    b[6] = {b[5][3:0], b[6][3:0]};
    b[5] = {b[5][7:4], b[4][7:4]};
    b[4] = {b[3][3:0], b[4][3:0]};
    b[3] = {b[3][7:4], t[7:4]};
    for (int k = 0; k < BYTES; k++) begin
      res[8*k +: 8] = b[k];
    end
    return res;
  endfunction

endpackage

// ===== hdl/lfbd_stage.sv =====
module lfbd_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [lfbd_pkg::SLOT_W-1:0] slot_i,
  input  logic                       last_i,
  input  lfbd_pkg::req_t             req_i,
  output lfbd_pkg::req_t             req_o
);

  logic [lfbd_pkg::KEY_W-1:0] key_q;
  logic                       vld_q;
  lfbd_pkg::action_e          act_q;
  logic [lfbd_pkg::BLK_W-1:0] data_q;
  logic [lfbd_pkg::BLK_W-1:0] data_d;
  logic                       key_we;

  always_comb begin
    data_d = req_i.data;
    if (req_i.act == lfbd_pkg::ACT_DECRYPT) begin
      data_d = lfbd_pkg::feistel_f(req_i.data, key_q);
      if (!last_i) begin
        data_d = lfbd_pkg::inv_shuffle(data_d);
      end
    end
  end

  assign key_we = adv_i && req_i.vld && (req_i.act == lfbd_pkg::ACT_LOAD) &&
                  (req_i.data[lfbd_pkg::KEY_W +: lfbd_pkg::SLOT_W] == slot_i);

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q <= req_i.data[lfbd_pkg::KEY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      act_q  <= req_i.act;
      data_q <= data_d;
    end
  end

  assign req_o = '{vld: vld_q, act: act_q, data: data_q};

endmodule

// ===== hdl/lightweight_feistel_block_decrypt.sv =====
// TWINE-64 decryption pipeline: one request enters per cycle while not stalled,
// and a decrypt shows its plaintext on plain_block_o after passing 35 round
// stages of one F-function plus inverse shuffle, one stage with the final
// F-function, then the output register; the first stage registers it at the
// edge of acceptance.
// Each stage holds the round key it uses. A load request travels down the
// pipeline in order and writes its key word into the matching stage as it
// passes, so it never alters decrypts ahead of it; it produces no output.
// Slots at or above 36 are dropped. A stall on the output while valid_o is
// high freezes the whole pipeline and raises stall_o.
module lightweight_feistel_block_decrypt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic                        action_i,
  input  logic [lfbd_pkg::SLOT_W-1:0] key_slot_i,
  input  logic [lfbd_pkg::KEY_W-1:0]  key_word_i,
  input  logic [lfbd_pkg::BLK_W-1:0]  cipher_block_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [lfbd_pkg::BLK_W-1:0]  plain_block_o
);

  lfbd_pkg::req_t             stg_req [lfbd_pkg::ROUNDS+1];
  logic                       adv;
  logic                       out_vld_q;
  logic [lfbd_pkg::BLK_W-1:0] out_data_q;
  lfbd_pkg::action_e          in_act;

  assign adv     = !(out_vld_q && stall_i);
  assign stall_o = !adv;
  assign in_act  = lfbd_pkg::action_e'(action_i);

  assign stg_req[0].vld  = valid_i;
  assign stg_req[0].act  = in_act;
  assign stg_req[0].data = (in_act == lfbd_pkg::ACT_DECRYPT) ? cipher_block_i :
                           {{lfbd_pkg::PAD_W{1'b0}}, key_slot_i, key_word_i};

  for (genvar i = 0; i < lfbd_pkg::ROUNDS; i++) begin : g_stage
    lfbd_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .slot_i (lfbd_pkg::SLOT_W'(lfbd_pkg::ROUNDS - 1 - i)),
      .last_i (1'(i == lfbd_pkg::ROUNDS - 1)),
      .req_i  (stg_req[i]),
      .req_o  (stg_req[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= stg_req[lfbd_pkg::ROUNDS].vld &&
                   (stg_req[lfbd_pkg::ROUNDS].act == lfbd_pkg::ACT_DECRYPT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= stg_req[lfbd_pkg::ROUNDS].data;
    end
  end

  assign valid_o       = out_vld_q;
  assign plain_block_o = out_data_q;

  a_load_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_req[lfbd_pkg::ROUNDS].vld &&
     stg_req[lfbd_pkg::ROUNDS].act == lfbd_pkg::ACT_LOAD && !stall_o) |=> !valid_o)
    else $error("load request reached the output");

  a_out_from_decrypt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(adv) |-> $past(stg_req[lfbd_pkg::ROUNDS].vld &&
                                    stg_req[lfbd_pkg::ROUNDS].act == lfbd_pkg::ACT_DECRYPT))
    else $error("output valid without a decrypt in the last stage");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(stg_req[lfbd_pkg::ROUNDS].vld) && $stable(stg_req[1].vld))
    else $error("pipeline moved while stalled");

endmodule
